// ===== rtl/core/abo_pkg.sv =====
// Package for the alpha-beta angle observer.
// Holds widths, register indexes, controller states and the command struct.
// No dependencies.
`default_nettype none
package abo_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS      = 16;
  localparam int UNIT_W         = 16;
  localparam int SPEED_W        = 32;
  localparam int PGAIN_W        = 18;
  localparam int VGAIN_W        = 24;
  localparam int DELAY_W        = 16;
  localparam int POLES_W        = 7;
  localparam int OFFSET_W       = 16;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int MUL_A_W        = VGAIN_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_GAIN = 3'd0,
    REG_VEL_GAIN = 3'd1,
    REG_DELAY    = 3'd2,
    REG_POLES    = 3'd3,
    REG_OFFSET   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PGAIN_W-1:0]  position_gain;
    logic [VGAIN_W-1:0]  velocity_gain;
    logic [DELAY_W-1:0]  enc_delay;
    logic [POLES_W-1:0]  pole_count;
    logic [OFFSET_W-1:0] angle_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLY,
    ST_ERR,
    ST_POS,
    ST_VEL,
    ST_SPD,
    ST_EA,
    ST_EP
  } state_t;

  typedef enum logic [2:0] {
    MS_DLY,
    MS_POS,
    MS_VEL,
    MS_EA,
    MS_EP
  } mul_sel_t;

  typedef struct packed {
    logic     load_enc;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     err_en;
    logic     angle_en;
    logic     speed_en;
    logic     ea_en;
    logic     out_en;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/abo_regs.sv =====
// Configuration register file of the angle observer.
// Depends on abo_pkg.
`default_nettype none
module abo_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [abo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abo_pkg::CFG_DATA_W-1:0] cfg_data,
  output abo_pkg::cfg_t                      cfg
);
  import abo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_gain <= '0;
      cfg.velocity_gain <= '0;
      cfg.enc_delay     <= '0;
      cfg.pole_count    <= POLES_W'(1);
      cfg.angle_offset  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POS_GAIN: cfg.position_gain <= cfg_data[PGAIN_W-1:0];
        REG_VEL_GAIN: cfg.velocity_gain <= cfg_data[VGAIN_W-1:0];
        REG_DELAY:    cfg.enc_delay     <= cfg_data[DELAY_W-1:0];
        REG_POLES:    cfg.pole_count    <= cfg_data[POLES_W-1:0];
        REG_OFFSET:   cfg.angle_offset  <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/abo_ctrl.sv =====
// Controller of the angle observer: sequences the shared multiplier
// and owns the input and output handshakes. Depends on abo_pkg.
`default_nettype none
module abo_ctrl (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output abo_pkg::cmd_t cmd
);
  import abo_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_DLY;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_enc = 1'b1;
          state_next   = ST_DLY;
        end
      end
      ST_DLY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DLY;
        state_next  = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_next = ST_POS;
      end
      ST_POS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_POS;
        state_next  = ST_VEL;
      end
      ST_VEL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_VEL;
        cmd.angle_en = 1'b1;
        state_next   = ST_SPD;
      end
      ST_SPD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_EA;
        cmd.speed_en = 1'b1;
        state_next   = ST_EA;
      end
      ST_EA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_EP;
        cmd.ea_en   = 1'b1;
        state_next  = ST_EP;
      end
      ST_EP: begin
        if (!out_valid || out_ready) begin
          cmd.out_en = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_en) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/abo_dp.sv =====
// Datapath of the angle observer: estimates, error, shared multiplier
// and output registers. Depends on abo_pkg.
`default_nettype none
module abo_dp #(
  parameter int ANGLE_BITS = abo_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire abo_pkg::cfg_t                    cfg,
  input  wire abo_pkg::cmd_t                    cmd,
  input  wire logic [abo_pkg::UNIT_W-1:0]       encoder_angle,
  output logic [abo_pkg::UNIT_W-1:0]            mech_angle,
  output logic [abo_pkg::UNIT_W-1:0]            elec_angle,
  output logic signed [abo_pkg::SPEED_W-1:0]    mech_speed,
  output logic [abo_pkg::UNIT_W-1:0]            mech_angle_ahead,
  output logic [abo_pkg::UNIT_W-1:0]            elec_angle_pred
);
  import abo_pkg::*;

  localparam int TB = ANGLE_BITS + FRAC_BITS;
  localparam int AW = MUL_A_W;
  localparam int BW = (TB + 1 > SPEED_W) ? TB + 1 : SPEED_W;
  localparam int PW = AW + BW;
  localparam logic signed [PW:0] RND8  = 128;
  localparam logic signed [PW:0] RND16 = 32768;
  localparam logic signed [PW:0] RND24 = 8388608;
  localparam logic signed [PW:0] SMAX  = 2147483647;
  localparam logic signed [PW:0] SMIN  = -SMAX - 1;

  logic [UNIT_W-1:0]        enc_r;
  logic [TB-1:0]            angle_est;
  logic signed [SPEED_W-1:0] speed_est;
  logic signed [TB:0]       err_r;
  logic [TB-1:0]            pred_r;
  logic [UNIT_W-1:0]        ea_r;

  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [PW:0]       prod_x;
  logic signed [PW:0]       rnd8, rnd16, rnd24, ns_wide;
  logic signed [SPEED_W-1:0] ns_sat;
  logic [ANGLE_BITS-1:0]    enc_unit, off_unit;
  logic [TB-1:0]            off_full, comp, u, ang_off, pred_off, pred_next, angle_next;
  logic [UNIT_W-1:0]        elec_now;

  assign enc_unit = ANGLE_BITS'(enc_r);
  assign off_unit = ANGLE_BITS'(cfg.angle_offset);
  assign off_full = {off_unit, FRAC_BITS'(0)};
  assign ang_off  = angle_est + off_full;
  assign pred_off = pred_r + off_full;

  always_comb begin
    mul_a = AW'(cfg.enc_delay);
    mul_b = BW'(speed_est);
    case (cmd.mul_sel)
      MS_DLY: begin
        mul_a = AW'(cfg.enc_delay);
        mul_b = BW'(speed_est);
      end
      MS_POS: begin
        mul_a = AW'(cfg.position_gain);
        mul_b = BW'(err_r);
      end
      MS_VEL: begin
        mul_a = AW'(cfg.velocity_gain);
        mul_b = BW'(err_r);
      end
      MS_EA: begin
        mul_a = AW'(cfg.pole_count);
        mul_b = BW'(ang_off);
      end
      MS_EP: begin
        mul_a = AW'(cfg.pole_count);
        mul_b = BW'(pred_off);
      end
      default: ;
    endcase
  end

  assign prod_x = (PW+1)'(prod);
  assign rnd8   = (prod_x + RND8) >>> 8;
  assign rnd16  = (prod_x + RND16) >>> 16;
  assign rnd24  = (prod_x + RND24) >>> 24;

  // wrapped error, exact half turn counts as positive
  assign comp = {enc_unit, FRAC_BITS'(0)} + TB'(rnd8);
  assign u    = comp - angle_est;

  assign angle_next = angle_est + TB'(speed_est) + TB'(rnd16);

  assign ns_wide = rnd24 + (PW+1)'(speed_est);
  always_comb begin
    if (ns_wide > SMAX) begin
      ns_sat = SPEED_W'(SMAX);
    end else if (ns_wide < SMIN) begin
      ns_sat = SPEED_W'(SMIN);
    end else begin
      ns_sat = ns_wide[SPEED_W-1:0];
    end
  end
  assign pred_next = angle_est + TB'(ns_sat);

  assign elec_now = UNIT_W'(prod[TB-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_est <= '0;
      speed_est <= '0;
    end else begin
      if (cmd.angle_en) begin
        angle_est <= angle_next;
      end
      if (cmd.speed_en) begin
        speed_est <= ns_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      enc_r <= encoder_angle;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.err_en) begin
      err_r <= {u[TB-1] & (|u[TB-2:0]), u};
    end
    if (cmd.speed_en) begin
      pred_r <= pred_next;
    end
    if (cmd.ea_en) begin
      ea_r <= elec_now;
    end
    if (cmd.out_en) begin
      mech_angle       <= UNIT_W'(angle_est[TB-1:FRAC_BITS]);
      elec_angle       <= ea_r;
      mech_speed       <= speed_est;
      mech_angle_ahead <= UNIT_W'(pred_r[TB-1:FRAC_BITS]);
      elec_angle_pred  <= elec_now;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/alpha_beta_angle_observer.sv =====
// Top level of the alpha-beta angle tracking observer.
// Instantiates abo_regs, abo_ctrl and abo_dp; depends on abo_pkg.
//
//   channel   dir   handshake              payload
//   input     in    in_valid / in_ready    encoder_angle
//   output    out   out_valid / out_ready  mech_angle, elec_angle, mech_speed,
//                                          mech_angle_ahead, elec_angle_pred
//   config    in    cfg_write              cfg_index, cfg_data
//
// Each sample runs from the transfer cycle through seven controller steps, five
// of which each use the one shared multiplier; a new sample is taken only in idle.
// The last step waits while the previous result is still held unread.
// Reset (rst, synchronous) clears the config registers (pole count to 1), estimates and output valid.
`default_nettype none
module alpha_beta_angle_observer #(
  parameter int ANGLE_BITS = abo_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [abo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [abo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [abo_pkg::UNIT_W-1:0]        encoder_angle,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [abo_pkg::UNIT_W-1:0]             mech_angle,
  output logic [abo_pkg::UNIT_W-1:0]             elec_angle,
  output logic signed [abo_pkg::SPEED_W-1:0]     mech_speed,
  output logic [abo_pkg::UNIT_W-1:0]             mech_angle_ahead,
  output logic [abo_pkg::UNIT_W-1:0]             elec_angle_pred
);
  import abo_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  abo_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  abo_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .encoder_angle    (encoder_angle),
    .mech_angle       (mech_angle),
    .elec_angle       (elec_angle),
    .mech_speed       (mech_speed),
    .mech_angle_ahead (mech_angle_ahead),
    .elec_angle_pred  (elec_angle_pred)
  );

endmodule
`default_nettype wire
